@@ sv/vdl_pkg.sv @@
package vdl_pkg;

	localparam int SqrtSteps = 25;
	localparam int DivSteps  = 16;
	localparam logic [16:0] OneQ15 = 17'd32768;

	typedef enum logic [2:0] {
		REG_LIGHT_X  = 3'd0,
		REG_LIGHT_Y  = 3'd1,
		REG_LIGHT_Z  = 3'd2,
		REG_AMBIENT  = 3'd3,
		REG_DIFFUSE  = 3'd4
	} reg_idx_t;

	// One vector on its way to unit length.
	typedef struct packed {
		logic [2:0][16:0] mag;
		logic [2:0]       neg;
		logic [49:0]      rem;
		logic [24:0]      root;
		logic [2:0][39:0] drem;
		logic [2:0][15:0] quo;
	} vec_t;

	typedef struct packed {
		vec_t nrm;
		vec_t dir;
	} pair_t;

	// One bit of the integer square root.
	function automatic vec_t sqrt_step(vec_t v, int b);
		logic [50:0] trial;
		vec_t        r;
		r = v;
		trial = ({26'd0, v.root} << (b + 1)) + (51'd1 << (2 * b));
		if ({1'b0, v.rem} >= trial) begin
			r.rem  = v.rem - trial[49:0];
			r.root = v.root | (25'd1 << b);
		end
		return r;
	endfunction

	// One quotient bit for all three components.
	function automatic vec_t div_step(vec_t v, int b);
		logic [40:0] trial;
		vec_t        r;
		r = v;
		trial = {16'd0, v.root} << b;
		for (int i = 0; i < 3; i++) begin
			if ({1'b0, v.drem[i]} >= trial) begin
				r.drem[i]   = v.drem[i] - trial[39:0];
				r.quo[i][b] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic vec_t div_init(vec_t v);
		vec_t r;
		r = v;
		for (int i = 0; i < 3; i++) begin
			r.drem[i] = {v.mag[i], 23'd0};
			r.quo[i]  = '0;
		end
		return r;
	endfunction

	// Clamp, apply sign; a zero root means a zero-length vector.
	function automatic logic signed [16:0] unit_comp(vec_t v, int i);
		logic [16:0] q;
		q = {1'b0, v.quo[i]};
		if (q > OneQ15) begin
			q = OneQ15;
		end
		if (v.root == '0) begin
			q = '0;
		end
		return v.neg[i] ? -$signed(q) : $signed(q);
	endfunction

endpackage

@@ sv/vertex_diffuse_lighting.sv @@
// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// vertex in | in_valid, in_stall, point_*, normal_*     | in
// result    | out_valid, out_stall, diffuse_level,shade | out
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One vertex per clock while no result is stalled; the pipe holds the 25-stage square
// root and 16-stage divider, one bit per stage, plus eight stages of set-up,
// products, clamp, weighting and output.
// Reset clears every stage valid and loads the register defaults.
// A stalled result freezes the whole pipe; in_stall follows it, so no item is
// lost or repeated. A waiting result holds the input too; bubbles stay in place.
module vertex_diffuse_lighting (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] point_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        diffuse_level,
	output logic [15:0]        shade,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import vdl_pkg::*;

	logic signed [15:0] light_x_q, light_y_q, light_z_q;
	logic [15:0]        ambient_q, diffuse_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= 16'sd0;
			light_y_q <= 16'sd0;
			light_z_q <= 16'sd2560;
			ambient_q <= 16'd9830;
			diffuse_q <= 16'd22938;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIGHT_X: light_x_q <= cfg_data;
				REG_LIGHT_Y: light_y_q <= cfg_data;
				REG_LIGHT_Z: light_z_q <= cfg_data;
				REG_AMBIENT: ambient_q <= cfg_data;
				REG_DIFFUSE: diffuse_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipe advances unless the output holds an untaken result.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: light direction and magnitudes.
	logic signed [16:0] dir_c [3];
	logic signed [16:0] nrm_c [3];
	always_comb begin
		dir_c[0] = 17'(light_x_q) - 17'(point_x);
		dir_c[1] = 17'(light_y_q) - 17'(point_y);
		dir_c[2] = 17'(light_z_q) - 17'(point_z);
		nrm_c[0] = 17'(normal_x);
		nrm_c[1] = 17'(normal_y);
		nrm_c[2] = 17'(normal_z);
	end

	pair_t pin_c;
	always_comb begin
		pin_c = '0;
		for (int i = 0; i < 3; i++) begin
			pin_c.dir.neg[i] = dir_c[i][16];
			pin_c.dir.mag[i] = dir_c[i][16] ? 17'(-dir_c[i]) : 17'(dir_c[i]);
			pin_c.nrm.neg[i] = nrm_c[i][16];
			pin_c.nrm.mag[i] = nrm_c[i][16] ? 17'(-nrm_c[i]) : 17'(nrm_c[i]);
		end
	end

	logic              vld_s1;
	pair_t             p_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= pin_c;
		end
	end

	// Stage 2: squares.
	logic              vld_s2;
	pair_t             p_s2;
	logic [2:0][33:0]  sqd_s2, sqn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= p_s1;
			for (int i = 0; i < 3; i++) begin
				sqd_s2[i] <= 34'(p_s1.dir.mag[i] * p_s1.dir.mag[i]);
				sqn_s2[i] <= 34'(p_s1.nrm.mag[i] * p_s1.nrm.mag[i]);
			end
		end
	end

	// Stage 3: sum of squares, scaled into the root radicand.
	pair_t sum_c;
	always_comb begin
		sum_c          = p_s2;
		sum_c.dir.rem  = {sqd_s2[0] + sqd_s2[1] + sqd_s2[2], 16'd0};
		sum_c.nrm.rem  = {sqn_s2[0] + sqn_s2[1] + sqn_s2[2], 16'd0};
		sum_c.dir.root = '0;
		sum_c.nrm.root = '0;
	end

	logic  vld_s3;
	pair_t p_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3 <= sum_c;
		end
	end

	// Square root, one bit per stage, top bit first.
	logic  vld_sq_s [SqrtSteps + 1];
	pair_t p_sq_s   [SqrtSteps + 1];
	assign vld_sq_s[0] = vld_s3;
	assign p_sq_s[0]   = p_s3;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq_s[k + 1] <= 1'b0;
			end else if (adv) begin
				vld_sq_s[k + 1] <= vld_sq_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				p_sq_s[k + 1].nrm <= sqrt_step(p_sq_s[k].nrm, SqrtSteps - 1 - k);
				p_sq_s[k + 1].dir <= sqrt_step(p_sq_s[k].dir, SqrtSteps - 1 - k);
			end
		end
	end

	// Divider: each component magnitude scaled by 2^23 over the root.
	logic  vld_dv_s [DivSteps + 1];
	pair_t p_dv_s   [DivSteps + 1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv_s[0] <= 1'b0;
		end else if (adv) begin
			vld_dv_s[0] <= vld_sq_s[SqrtSteps];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_dv_s[0].nrm <= div_init(p_sq_s[SqrtSteps].nrm);
			p_dv_s[0].dir <= div_init(p_sq_s[SqrtSteps].dir);
		end
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[k + 1] <= 1'b0;
			end else if (adv) begin
				vld_dv_s[k + 1] <= vld_dv_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				p_dv_s[k + 1].nrm <= div_step(p_dv_s[k].nrm, DivSteps - 1 - k);
				p_dv_s[k + 1].dir <= div_step(p_dv_s[k].dir, DivSteps - 1 - k);
			end
		end
	end

	// Products of unit components.
	logic                     vld_pr_s;
	logic signed [33:0]       prod_pr_s [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pr_s <= 1'b0;
		end else if (adv) begin
			vld_pr_s <= vld_dv_s[DivSteps];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				prod_pr_s[i] <= unit_comp(p_dv_s[DivSteps].nrm, i)
					* unit_comp(p_dv_s[DivSteps].dir, i);
			end
		end
	end

	// Dot product, clamp to [0, 1.0].
	logic signed [35:0] dot_c;
	logic [16:0]        lvl_c;
	always_comb begin
		dot_c = 36'(prod_pr_s[0]) + 36'(prod_pr_s[1]) + 36'(prod_pr_s[2]);
		if (dot_c <= 0) begin
			lvl_c = '0;
		end else if (dot_c[35:15] > 21'(OneQ15)) begin
			lvl_c = OneQ15;
		end else begin
			lvl_c = dot_c[31:15];
		end
	end

	logic        vld_lv_s;
	logic [16:0] lvl_lv_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_lv_s <= 1'b0;
		end else if (adv) begin
			vld_lv_s <= vld_pr_s;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lvl_lv_s <= lvl_c;
		end
	end

	// Weight by the diffuse gain.
	logic        vld_wt_s;
	logic [16:0] lvl_wt_s;
	logic [32:0] wt_wt_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_wt_s <= 1'b0;
		end else if (adv) begin
			vld_wt_s <= vld_lv_s;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lvl_wt_s <= lvl_lv_s;
			wt_wt_s  <= lvl_lv_s * diffuse_q;
		end
	end

	// Add ambient, saturate, and hold in the output register.
	logic [18:0] shade_c;
	assign shade_c = 19'(ambient_q) + 19'(wt_wt_s[32:15]);

	logic        vld_out_q;
	logic [15:0] lvl_q, shade_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= vld_wt_s;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lvl_q   <= lvl_wt_s[15:0];
			shade_q <= (shade_c > 19'(OneQ15)) ? 16'(OneQ15) : shade_c[15:0];
		end
	end

	assign out_valid     = vld_out_q;
	assign diffuse_level = lvl_q;
	assign shade         = shade_q;

endmodule
